@@ design/epdwpp_pkg.sv @@
`timescale 1ns / 1ps

package epdwpp_pkg;

    localparam int LEVEL_BITS       = 5;
    localparam int STEP_BITS        = 6;
    localparam int PHASE_BITS       = 2;
    localparam int PIXELS_PER_GROUP = 8;
    localparam int GROUP_BITS       = LEVEL_BITS * PIXELS_PER_GROUP;

    localparam int DEF_LEVEL_COUNT     = 32;
    localparam int DEF_MAX_FRAME_STEPS = 64;

    localparam logic ACTION_WRITE   = 1'b0;
    localparam logic ACTION_CONVERT = 1'b1;

    typedef logic [LEVEL_BITS-1:0] level_t;
    typedef logic [STEP_BITS-1:0]  step_t;
    typedef logic [PHASE_BITS-1:0] phase_t;

    typedef struct packed {
        logic                  action;
        step_t                 frame_step;
        logic [GROUP_BITS-1:0] prev_levels;
        logic [GROUP_BITS-1:0] next_levels;
        level_t                entry_prev_level;
        level_t                entry_next_level;
        phase_t                entry_phase;
    } cmd_word_t;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
    } res_word_t;

    typedef phase_t [PIXELS_PER_GROUP-1:0] phase_vec_t;

endpackage

@@ design/epd_waveform_phase_packer.sv @@
`timescale 1ns / 1ps

// E-paper waveform phase packer.
// Input channel cmd (cmd_valid / cmd_stall / cmd): a word with action 0 stores one
// 2-bit phase into the table at (frame_step, entry_prev_level, entry_next_level) and
// gives no result; a word with action 1 looks up eight pixels and gives one result.
// Output channel res (res_valid / res_stall / res): first_byte holds pixels 5..8,
// second_byte pixels 1..4, earlier pixel in the higher bits.
// Throughput is one word per cycle while cmd_stall is low. For a convert, the eight
// lanes register the table read when the word is accepted, and the output register
// then loads the packed result, which is shown on res.
// Each lane keeps its own full copy of the table with one read port; writes go to
// all copies at once, so a convert directly after a write sees the new entry.
// Reset clears only the pipeline valid bits; table contents stay undefined until
// written, and no clearing pass runs.
// While res_stall is high the result holds; the lane stage still takes words until
// a convert lands in it, after which cmd_stall rises until res drains.
module epd_waveform_phase_packer
    import epdwpp_pkg::*;
#(
    parameter int LEVEL_COUNT     = DEF_LEVEL_COUNT,
    parameter int MAX_FRAME_STEPS = DEF_MAX_FRAME_STEPS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_word_t res
);

    logic       lane_valid_reg;
    logic       lane_valid_next;
    logic       lane_en;
    logic       take;
    logic       accept;
    logic       do_write;
    logic       do_read;
    phase_vec_t lane_phase;

    assign lane_en   = !lane_valid_reg || take;
    assign cmd_stall = !lane_en;
    assign accept    = cmd_valid && lane_en;
    assign do_write  = accept && (cmd.action == ACTION_WRITE);
    assign do_read   = accept && (cmd.action == ACTION_CONVERT);

    assign lane_valid_next = lane_en ? do_read : lane_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
        end
        else
        begin
            lane_valid_reg <= lane_valid_next;
        end
    end

    for (genvar j = 0; j < PIXELS_PER_GROUP; j++)
    begin : g_lane
        epdwpp_lane #(
            .LEVEL_COUNT     (LEVEL_COUNT),
            .MAX_FRAME_STEPS (MAX_FRAME_STEPS)
        ) u_lane (
            .clk      (clk),
            .rd_en    (do_read),
            .rd_step  (cmd.frame_step),
            .rd_prev  (cmd.prev_levels[j*LEVEL_BITS +: LEVEL_BITS]),
            .rd_next  (cmd.next_levels[j*LEVEL_BITS +: LEVEL_BITS]),
            .wr_en    (do_write),
            .wr_step  (cmd.frame_step),
            .wr_prev  (cmd.entry_prev_level),
            .wr_next  (cmd.entry_next_level),
            .wr_phase (cmd.entry_phase),
            .phase    (lane_phase[j])
        );
    end

    epdwpp_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_valid (lane_valid_reg),
        .lane_phase (lane_phase),
        .take       (take),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule

@@ design/epdwpp_lane.sv @@
`timescale 1ns / 1ps

module epdwpp_lane
    import epdwpp_pkg::*;
#(
    parameter int LEVEL_COUNT     = DEF_LEVEL_COUNT,
    parameter int MAX_FRAME_STEPS = DEF_MAX_FRAME_STEPS
)
(
    input  logic   clk,
    input  logic   rd_en,
    input  step_t  rd_step,
    input  level_t rd_prev,
    input  level_t rd_next,
    input  logic   wr_en,
    input  step_t  wr_step,
    input  level_t wr_prev,
    input  level_t wr_next,
    input  phase_t wr_phase,
    output phase_t phase
);

    localparam int DEPTH  = MAX_FRAME_STEPS * LEVEL_COUNT * LEVEL_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);

    // One private copy of the whole phase table, so every lane has its own read port.
    phase_t mem [DEPTH];

    logic [31:0]       rd_wide;
    logic [31:0]       wr_wide;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_ok;
    logic              wr_ok;
    phase_t            rd_data_reg;
    logic              rd_ok_reg;

    always_comb
    begin
        rd_wide = (32'(rd_step) * 32'(LEVEL_COUNT) + 32'(rd_prev)) * 32'(LEVEL_COUNT)
                  + 32'(rd_next);
        wr_wide = (32'(wr_step) * 32'(LEVEL_COUNT) + 32'(wr_prev)) * 32'(LEVEL_COUNT)
                  + 32'(wr_next);
        rd_addr = rd_wide[ADDR_W-1:0];
        wr_addr = wr_wide[ADDR_W-1:0];
        rd_ok   = (32'(rd_step) < 32'(MAX_FRAME_STEPS)) && (32'(rd_prev) < 32'(LEVEL_COUNT))
                  && (32'(rd_next) < 32'(LEVEL_COUNT));
        wr_ok   = (32'(wr_step) < 32'(MAX_FRAME_STEPS)) && (32'(wr_prev) < 32'(LEVEL_COUNT))
                  && (32'(wr_next) < 32'(LEVEL_COUNT));
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_ok)
        begin
            mem[wr_addr] <= wr_phase;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_ok_reg   <= rd_ok;
        end
    end

    // A pixel whose indexes fall outside the table drives phase zero.
    assign phase = rd_ok_reg ? rd_data_reg : '0;

endmodule

@@ design/epdwpp_merge.sv @@
`timescale 1ns / 1ps

module epdwpp_merge
    import epdwpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       lane_valid,
    input  phase_vec_t lane_phase,
    output logic       take,
    output logic       res_valid,
    input  logic       res_stall,
    output res_word_t  res
);

    logic      res_valid_reg;
    logic      res_valid_next;
    res_word_t res_reg;
    res_word_t res_next;

    assign take = !res_valid_reg || !res_stall;

    // The earlier pixel lands in the higher bits of each byte.
    always_comb
    begin
        res_next.first_byte  = {lane_phase[4], lane_phase[5], lane_phase[6], lane_phase[7]};
        res_next.second_byte = {lane_phase[0], lane_phase[1], lane_phase[2], lane_phase[3]};
        res_valid_next       = take ? lane_valid : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && lane_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
